[rtl/sorted_key_table_lookup_assert.svh]
// Assertion macros for the sorted key table lookup block.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef SORTED_KEY_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_KEY_TABLE_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SKL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SKL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKL_ASSERT_IMP(lbl, ante, cons)
`define SKL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/skl_pkg.sv]
// Shared types, constants and key helper for the sorted key table lookup.
// No dependencies.
package skl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 80;
  localparam int MASK_W      = 64;
  localparam int MASKS_W     = 4 * MASK_W;
  localparam int ENTRY_W     = KEY_W + MASKS_W;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_MATCH_RD,
    S_MATCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_LO,
    RD_MID,
    RD_SHIFT
  } rd_src_t;

  typedef struct packed {
    logic       capture;
    logic       clear_count;
    rd_src_t    rd_src;
    logic       search_step;
    logic       shift_init;
    logic       shift_wr;
    logic       ins_wr;
    logic       set_status;
    logic [2:0] status_val;
    logic       res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_insert;
    logic full;
    logic search_open;
    logic lo_in_range;
    logic shift_more;
    logic key_eq;
    logic out_free;
  } dp_stat_t;

  // Signed parts get their sign bit flipped so one unsigned compare orders the key.
  function automatic logic [KEY_W-1:0] make_key(logic [31:0] pep, logic [31:0] md,
                                                logic [7:0] nt, logic [7:0] ct);
    return {pep, md ^ 32'h8000_0000, nt ^ 8'h80, ct ^ 8'h80};
  endfunction

endpackage

[rtl/skl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module skl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/skl_ctrl.sv]
// Sequencer for clear, insert (search then shift) and lookup (search then match).
// Depends on skl_pkg.
module skl_ctrl import skl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.is_clear || (stat.is_insert && stat.full)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SEARCH_RD;
        end
      end
      S_SEARCH_RD: begin
        if (stat.search_open) state_next = S_SEARCH_CMP;
        else if (stat.is_insert) state_next = S_SHIFT_RD;
        else state_next = S_MATCH_RD;
      end
      S_SEARCH_CMP: state_next = S_SEARCH_RD;
      S_MATCH_RD:   state_next = stat.lo_in_range ? S_MATCH_CHK : S_DONE;
      S_MATCH_CHK:  state_next = S_DONE;
      S_SHIFT_RD:   state_next = stat.shift_more ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR:   state_next = S_SHIFT_RD;
      S_DONE:       if (stat.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_src = RD_LO;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd.capture = in_valid;
      S_DISPATCH: begin
        if (stat.is_clear) begin
          cmd.clear_count = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_val  = ST_CLEARED;
        end else if (stat.is_insert && stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_FULL;
        end
      end
      S_SEARCH_RD: begin
        if (stat.search_open) begin
          cmd.rd_src = RD_MID;
        end else if (stat.is_insert) begin
          cmd.shift_init = 1'b1;
        end
      end
      S_SEARCH_CMP: cmd.search_step = 1'b1;
      S_MATCH_RD: begin
        if (!stat.lo_in_range) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_MISS;
        end
      end
      S_MATCH_CHK: begin
        cmd.set_status = 1'b1;
        cmd.status_val = stat.key_eq ? ST_HIT : ST_MISS;
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.rd_src = RD_SHIFT;
        end else begin
          cmd.ins_wr     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_INSERTED;
        end
      end
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_DONE:     cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/skl_datapath.sv]
// Search bounds, shift index, entry count, table RAM and the output word register.
// Depends on skl_pkg and skl_ram.
module skl_datapath import skl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         action,
  input  logic [31:0]        peptide_index,
  input  logic signed [31:0] mod_index,
  input  logic signed [7:0]  nterm_code,
  input  logic signed [7:0]  cterm_code,
  input  logic [63:0]        b_mask_in,
  input  logic [63:0]        y_mask_in,
  input  logic [63:0]        b_loss_mask_in,
  input  logic [63:0]        y_loss_mask_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [63:0]        b_mask_out,
  output logic [63:0]        y_mask_out,
  output logic [63:0]        b_loss_mask_out,
  output logic [63:0]        y_loss_mask_out
);

  logic [1:0]         act;
  logic [KEY_W-1:0]   key;
  logic [MASKS_W-1:0] masks;
  logic [CNT_W-1:0]   lo, hi, mid, idx, count;
  logic [2:0]         pend_status;

  logic [CNT_W-1:0]   mid_c, idx_m1;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [ENTRY_W-1:0] rd_data, wdata;
  logic [KEY_W-1:0]   s_key;
  logic               we, go_right;

  assign mid_c  = lo + ((hi - lo) >> 1);
  assign idx_m1 = idx - 1'b1;
  assign s_key  = rd_data[ENTRY_W-1 -: KEY_W];

  // insert seeks the upper bound, lookup the lower bound
  assign go_right = (act == ACT_INSERT) ? !(key < s_key) : (s_key < key);

  always_comb begin
    unique case (cmd.rd_src)
      RD_MID:   raddr = mid_c[ADDR_W-1:0];
      RD_SHIFT: raddr = idx_m1[ADDR_W-1:0];
      default:  raddr = lo[ADDR_W-1:0];
    endcase
  end

  assign we    = cmd.shift_wr | cmd.ins_wr;
  assign waddr = cmd.shift_wr ? idx[ADDR_W-1:0] : lo[ADDR_W-1:0];
  assign wdata = cmd.shift_wr ? rd_data : {key, masks};

  skl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act   <= action;
      key   <= make_key(peptide_index, mod_index, nterm_code, cterm_code);
      masks <= {b_mask_in, y_mask_in, b_loss_mask_in, y_loss_mask_in};
      lo    <= '0;
      hi    <= count;
    end else if (cmd.search_step) begin
      if (go_right) lo <= mid + 1'b1;
      else hi <= mid;
    end
    if (cmd.rd_src == RD_MID) mid <= mid_c;
    if (cmd.shift_init) idx <= count;
    else if (cmd.shift_wr) idx <= idx_m1;
    if (cmd.set_status) pend_status <= cmd.status_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.ins_wr) begin
      count <= count + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= pend_status;
      if (pend_status == ST_HIT) begin
        {b_mask_out, y_mask_out, b_loss_mask_out, y_loss_mask_out} <= rd_data[MASKS_W-1:0];
      end else begin
        {b_mask_out, y_mask_out, b_loss_mask_out, y_loss_mask_out} <= '1;
      end
    end
  end

  assign stat.is_clear    = (act == ACT_CLEAR);
  assign stat.is_insert   = (act == ACT_INSERT);
  assign stat.full        = (count == CNT_W'(TABLE_DEPTH));
  assign stat.search_open = (lo < hi);
  assign stat.lo_in_range = (lo < count);
  assign stat.shift_more  = (idx > lo);
  assign stat.key_eq      = (s_key == key);
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

[rtl/sorted_key_table_lookup.sv]
// Sorted key table lookup: a table of up to TABLE_DEPTH entries kept in key order.
// Input channel (in_valid / in_stall) carries one word per action: clear,
// insert (key plus four 64-bit masks) or look up (key). Output channel
// (out_valid / out_stall) returns one word per input word: a status code and
// four masks, the stored masks on a hit and all ones otherwise.
// One input word is in flight at a time. A lookup runs a binary search over the
// n stored entries; each probe is a registered read of the single table RAM
// followed by a compare. An insert searches, then moves each entry above its
// place down by one slot, a read and a write per entry; a clear or a
// full-table insert does no search and no table access.
// The result sits in an output register; the next word is accepted while it
// waits, and a stalled receiver only holds back the following result.
// Reset (synchronous, active high) empties the table and drops any pending
// result; table contents are not cleared, the entry count bounds all reads.
// Depends on skl_pkg, skl_ctrl, skl_datapath, skl_ram and the assertion header.
`include "sorted_key_table_lookup_assert.svh"
module sorted_key_table_lookup import skl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [31:0]        peptide_index,
  input  logic signed [31:0] mod_index,
  input  logic signed [7:0]  nterm_code,
  input  logic signed [7:0]  cterm_code,
  input  logic [63:0]        b_mask_in,
  input  logic [63:0]        y_mask_in,
  input  logic [63:0]        b_loss_mask_in,
  input  logic [63:0]        y_loss_mask_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [63:0]        b_mask_out,
  output logic [63:0]        y_mask_out,
  output logic [63:0]        b_loss_mask_out,
  output logic [63:0]        y_loss_mask_out
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: owns the input handshake and all step decisions
  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: bounds, table RAM, count and result register
  skl_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .action          (action),
    .peptide_index   (peptide_index),
    .mod_index       (mod_index),
    .nterm_code      (nterm_code),
    .cterm_code      (cterm_code),
    .b_mask_in       (b_mask_in),
    .y_mask_in       (y_mask_in),
    .b_loss_mask_in  (b_loss_mask_in),
    .y_loss_mask_in  (y_loss_mask_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .b_mask_out      (b_mask_out),
    .y_mask_out      (y_mask_out),
    .b_loss_mask_out (b_loss_mask_out),
    .y_loss_mask_out (y_loss_mask_out)
  );

  // busy right after a word is taken
  `SKL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new entry never lands in a full table
  `SKL_ASSERT_IMP(a_no_write_when_full, cmd.ins_wr, !stat.full)
  // result loads only into a free output register
  `SKL_ASSERT_IMP(a_load_when_free, cmd.res_load, stat.out_free)
  // shift move and new-entry write never share a cycle
  `SKL_ASSERT_IMP(a_single_writer, 1'b1, $onehot0({cmd.shift_wr, cmd.ins_wr}))

endmodule

[tb/tb_top.sv]
// Self-checking testbench for sorted_key_table_lookup: clear, insert and lookup words
// against a queue-based model of the ordered table. Depends on skl_pkg and the RTL top.
module tb_top;
  import skl_pkg::*;

  // Lookup codes are not named in the package; code 3 is a spare that acts as a lookup.
  localparam logic [1:0]  ACT_LOOKUP = 2'd2;
  localparam logic [1:0]  ACT_SPARE  = 2'd3;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};
  localparam int WATCHDOG_LIMIT = 40000;  // outlasts the longest shift, at full depth
  localparam int HOLD_AT        = 400;    // result count that starts the long hold-off
  localparam int HOLD_LEN       = 300;
  localparam int PHASE_WORDS    = 256;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] pep;
    logic [31:0] mod;
    logic [7:0]  nt;
    logic [7:0]  ct;
  } key_fields_t;

  typedef struct packed {
    logic [1:0]  act;
    key_fields_t k;
    logic [63:0] bm;
    logic [63:0] ym;
    logic [63:0] blm;
    logic [63:0] ylm;
  } cmd_word_t;

  typedef struct packed {
    logic [79:0] ord;
    logic [63:0] bm;
    logic [63:0] ym;
    logic [63:0] blm;
    logic [63:0] ylm;
  } entry_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [63:0] bm;
    logic [63:0] ym;
    logic [63:0] blm;
    logic [63:0] ylm;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  action         = '0;
  logic [31:0] peptide_index  = '0;
  logic [31:0] mod_index      = '0;
  logic [7:0]  nterm_code     = '0;
  logic [7:0]  cterm_code     = '0;
  logic [63:0] b_mask_in      = '0;
  logic [63:0] y_mask_in      = '0;
  logic [63:0] b_loss_mask_in = '0;
  logic [63:0] y_loss_mask_in = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [2:0]  status;
  logic [63:0] b_mask_out;
  logic [63:0] y_mask_out;
  logic [63:0] b_loss_mask_out;
  logic [63:0] y_loss_mask_out;

  // Stimulus and checking state
  cmd_word_t   pend_q[$];       // words waiting to be offered
  reply_t      reply_q[$];      // predicted replies, oldest first
  entry_t      table_model[$];  // model of the table, kept in key order
  key_fields_t key_hist[$];     // recently inserted keys, for lookups that should hit
  cmd_word_t   offer;           // word currently on the input port
  reply_t      got;
  reply_t      want;

  int n_pushed    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int quiet       = 0;

  always #6 clk = ~clk;

  sorted_key_table_lookup dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .peptide_index   (peptide_index),
    .mod_index       (mod_index),
    .nterm_code      (nterm_code),
    .cterm_code      (cterm_code),
    .b_mask_in       (b_mask_in),
    .y_mask_in       (y_mask_in),
    .b_loss_mask_in  (b_loss_mask_in),
    .y_loss_mask_in  (y_loss_mask_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .b_mask_out      (b_mask_out),
    .y_mask_out      (y_mask_out),
    .b_loss_mask_out (b_loss_mask_out),
    .y_loss_mask_out (y_loss_mask_out)
  );

  // Flip the sign bits of the signed parts so one unsigned compare gives the key order.
  function automatic logic [79:0] order_of(key_fields_t k);
    return {k.pep, ~k.mod[31], k.mod[30:0], ~k.nt[7], k.nt[6:0], ~k.ct[7], k.ct[6:0]};
  endfunction

  // Model of one word: updates the table copy and queues the reply it should give.
  task automatic apply_to_table(input cmd_word_t w);
    reply_t      rp;
    entry_t      e;
    logic [79:0] ko;
    int          lo;
    int          hi;
    int          mid;
    ko     = order_of(w.k);
    rp.st  = ST_MISS;
    rp.bm  = ALL_ONES;
    rp.ym  = ALL_ONES;
    rp.blm = ALL_ONES;
    rp.ylm = ALL_ONES;
    if (w.act == ACT_CLEAR) begin
      table_model.delete();
      rp.st = ST_CLEARED;
    end else if (w.act == ACT_INSERT) begin
      if (table_model.size() >= TABLE_DEPTH) begin
        rp.st = ST_FULL;
      end else begin
        // upper bound: equal keys keep insertion order
        lo = 0;
        hi = table_model.size();
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (table_model[mid].ord <= ko) lo = mid + 1;
          else hi = mid;
        end
        e.ord = ko;
        e.bm  = w.bm;
        e.ym  = w.ym;
        e.blm = w.blm;
        e.ylm = w.ylm;
        table_model.insert(lo, e);
        rp.st = ST_INSERTED;
      end
    end else begin
      // lower bound, then exact match on the first candidate
      lo = 0;
      hi = table_model.size();
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (table_model[mid].ord < ko) lo = mid + 1;
        else hi = mid;
      end
      if (lo < table_model.size() && table_model[lo].ord == ko) begin
        rp.st  = ST_HIT;
        rp.bm  = table_model[lo].bm;
        rp.ym  = table_model[lo].ym;
        rp.blm = table_model[lo].blm;
        rp.ylm = table_model[lo].ylm;
      end
    end
    reply_q.push_back(rp);
  endtask

  function automatic key_fields_t mk_key(logic [31:0] pep, logic [31:0] mod,
                                         logic [7:0] nt, logic [7:0] ct);
    key_fields_t k;
    k.pep = pep;
    k.mod = mod;
    k.nt  = nt;
    k.ct  = ct;
    return k;
  endfunction

  task automatic send_word(input logic [1:0] act, input key_fields_t k,
                           input logic [63:0] bm, input logic [63:0] ym,
                           input logic [63:0] blm, input logic [63:0] ylm);
    cmd_word_t w;
    w.act = act;
    w.k   = k;
    w.bm  = bm;
    w.ym  = ym;
    w.blm = blm;
    w.ylm = ylm;
    pend_q.push_back(w);
    n_pushed++;
  endtask

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Key parts lean toward a few small values and the extremes so equal and
  // neighboring keys are common; full-range values keep every bit toggling.
  function automatic key_fields_t rand_key();
    key_fields_t k;
    case ($urandom_range(0, 4))
      0:       k.pep = '0;
      1:       k.pep = '1;
      2, 3:    k.pep = $urandom_range(0, 3);
      default: k.pep = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       k.mod = 32'h8000_0000;
      1:       k.mod = 32'h7FFF_FFFF;
      2, 3:    k.mod = 32'($urandom_range(0, 4)) - 32'd2;
      default: k.mod = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       k.nt = 8'h80;
      1:       k.nt = 8'h7F;
      2, 3:    k.nt = 8'($urandom_range(0, 4)) - 8'd2;
      default: k.nt = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       k.ct = 8'h80;
      1:       k.ct = 8'h7F;
      2, 3:    k.ct = 8'($urandom_range(0, 4)) - 8'd2;
      default: k.ct = 8'($urandom);
    endcase
    return k;
  endfunction

  // One key part moved by one, so the search lands next to a stored key.
  function automatic key_fields_t nudge_key(key_fields_t k);
    logic [31:0] d;
    d = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
    case ($urandom_range(0, 3))
      0:       k.pep = k.pep + d;
      1:       k.mod = k.mod + d;
      2:       k.nt  = k.nt + d[7:0];
      default: k.ct  = k.ct + d[7:0];
    endcase
    return k;
  endfunction

  task automatic gen_random_word();
    key_fields_t k;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      send_word(ACT_CLEAR, rand_key(), rand_mask(), rand_mask(), rand_mask(), rand_mask());
    end else if (r < 40) begin
      if (key_hist.size() > 0 && $urandom_range(0, 5) == 0)
        k = key_hist[$urandom_range(0, key_hist.size() - 1)];
      else
        k = rand_key();
      send_word(ACT_INSERT, k, rand_mask(), rand_mask(), rand_mask(), rand_mask());
      key_hist.push_back(k);
      if (key_hist.size() > 64) void'(key_hist.pop_front());
    end else begin
      if (r < 70 && key_hist.size() > 0)
        k = key_hist[$urandom_range(0, key_hist.size() - 1)];
      else if (r < 85 && key_hist.size() > 0)
        k = nudge_key(key_hist[$urandom_range(0, key_hist.size() - 1)]);
      else
        k = rand_key();
      send_word((r >= 97) ? ACT_SPARE : ACT_LOOKUP, k,
                rand_mask(), rand_mask(), rand_mask(), rand_mask());
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || reply_q.size() != 0) @(posedge clk);
  endtask

  // Driver: a word is taken at an edge with in_valid high and in_stall low.
  // The model sees the word at that edge; the next word (or a gap) follows.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_table(offer);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          offer          = pend_q.pop_front();
          action         <= offer.act;
          peptide_index  <= offer.k.pep;
          mod_index      <= offer.k.mod;
          nterm_code     <= offer.k.nt;
          cterm_code     <= offer.k.ct;
          b_mask_in      <= offer.bm;
          y_mask_in      <= offer.ym;
          b_loss_mask_in <= offer.blm;
          y_loss_mask_in <= offer.ylm;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each reply with the oldest prediction and drives out_stall.
  // Once, at HOLD_AT replies, it starts the long hold-off, so the block's
  // output register and input side both back up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.st  = status;
        got.bm  = b_mask_out;
        got.ym  = y_mask_out;
        got.blm = b_loss_mask_out;
        got.ylm = y_loss_mask_out;
        if (reply_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("reply %0d arrived with nothing predicted: status %0d", n_results,
                     got.st);
        end else begin
          want = reply_q.pop_front();
          if (got.st !== want.st || got.bm !== want.bm || got.ym !== want.ym ||
              got.blm !== want.blm || got.ylm !== want.ylm) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("reply %0d mismatch: status exp %0d got %0d", n_results,
                       want.st, got.st);
              $display("  b      exp %h got %h", want.bm, got.bm);
              $display("  y      exp %h got %h", want.ym, got.ym);
              $display("  b_loss exp %h got %h", want.blm, got.blm);
              $display("  y_loss exp %h got %h", want.ylm, got.ylm);
            end
          end
        end
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_results == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    key_fields_t ka;
    key_fields_t kmin;
    key_fields_t kmax;
    int          p;
    int          i;

    ka   = mk_key(32'd5, 32'd0, 8'd0, 8'd0);
    kmin = mk_key(32'd0, 32'h8000_0000, 8'h80, 8'h80);
    kmax = mk_key('1, 32'h7FFF_FFFF, 8'h7F, 8'h7F);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme keys and masks, duplicates, signed order
    send_word(ACT_LOOKUP, kmin, '0, '0, '0, '0);               // empty table misses
    send_word(ACT_CLEAR, ka, '0, '0, '0, '0);
    send_word(ACT_INSERT, ka, '0, '0, '0, '0);
    send_word(ACT_INSERT, kmin, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(ACT_INSERT, kmax, rand_mask(), rand_mask(), rand_mask(), rand_mask());
    send_word(ACT_INSERT, ka, ALL_ONES, {$urandom, $urandom}, 64'd1, 64'd2); // duplicate
    send_word(ACT_INSERT, mk_key(32'd5, 32'hFFFF_FFFF, 8'd0, 8'd0),
              {$urandom, $urandom}, {$urandom, $urandom}, 64'd3, 64'd4);
    send_word(ACT_INSERT, mk_key(32'd5, 32'd0, 8'hFF, 8'd0),
              {$urandom, $urandom}, {$urandom, $urandom}, 64'd5, 64'd6);
    send_word(ACT_INSERT, mk_key(32'd5, 32'd0, 8'd0, 8'hFF),
              {$urandom, $urandom}, {$urandom, $urandom}, 64'd7, 64'd8);
    send_word(ACT_LOOKUP, ka, '1, '1, '1, '1);                 // earlier duplicate wins
    send_word(ACT_LOOKUP, kmin, '0, '0, '0, '0);
    send_word(ACT_LOOKUP, kmax, '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd5, 32'hFFFF_FFFF, 8'd0, 8'd0), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd5, 32'd0, 8'hFF, 8'd0), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd5, 32'd0, 8'd0, 8'hFF), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd5, 32'd0, 8'd0, 8'd1), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd5, 32'd1, 8'd0, 8'd0), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key(32'd4, 32'd0, 8'd0, 8'd0), '0, '0, '0, '0);
    send_word(ACT_SPARE, ka, '0, '0, '0, '0);                  // spare code reads only
    send_word(ACT_SPARE, mk_key(32'd6, 32'd0, 8'd0, 8'd0), '0, '0, '0, '0);
    send_word(ACT_LOOKUP, mk_key('1, 32'h7FFF_FFFF, 8'h7F, 8'h7E), '0, '0, '0, '0);
    send_word(ACT_CLEAR, kmax, '1, '1, '1, '1);
    send_word(ACT_LOOKUP, ka, '0, '0, '0, '0);                 // gone after clear
    send_word(ACT_INSERT, ka, {32{2'b01}}, {32{2'b10}}, {32{2'b10}}, {32{2'b01}});
    send_word(ACT_LOOKUP, ka, '0, '0, '0, '0);
    wait_drained();

    // Random words under each idling pattern
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 51; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (i = 0; i < PHASE_WORDS; i++) gen_random_word();
      wait_drained();
    end

    // Settle time for any stray reply
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
